FILE: hw/rtl/bsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int unsigned DataWidth = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        CFG_AC123 = 3'd0,
        CFG_AC456 = 3'd1,
        CFG_B12   = 3'd2,
        CFG_MCMD  = 3'd3,
        CFG_OSS   = 3'd4
    } cfg_index_t;

    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] P_C1      = 32'sd3038;
    localparam logic signed [31:0] P_C2      = -32'sd7357;
    localparam logic signed [31:0] P_C3      = 32'sd3791;
    localparam logic [31:0]        B7_SCALE  = 32'd50000;
    localparam logic signed [31:0] B4_OFFSET = 32'sd32768;
    localparam logic [31:0]        SIGN_BIT  = 32'h8000_0000;

endpackage
`default_nettype wire

FILE: hw/rtl/barometric_sensor_compensation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_unit
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects a raw temperature (0) or raw pressure (1),
// s_tdata carries the raw reading. Output stream: m_tuser gives the result
// kind, m_tdata the compensated value fields and the divide error flag.
// Calibration words and oversampling are written on the cfg channel, which
// is always ready; write it only while the block is idle.
// A sequencer drives one shared 32 by 32 multiplier for each product and
// one bit-serial divider for the division of each item.
// One item is in work at a time; s_tready is low from transfer until the
// result is loaded into the output register.
// A finished result waits in the output register while m_tready is low; a
// following item is taken and computed, then holds until the register frees.
// Reset clears the calibration registers, sets oversampling to 3 and clears
// the stored B5 term.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_unit
    import bsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // raw_reading[23:0]
    input  wire logic [0:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // temperature_tenths[15:0],
                                        // pressure_pascal[33:16],
                                        // divide_error[34], zero pad
    output logic      [0:0]  m_tuser,   // kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam logic [3:0] STEP_T_MUL   = 4'd0;
    localparam logic [3:0] STEP_T_DEN   = 4'd1;
    localparam logic [3:0] STEP_P_SQM   = 4'd2;
    localparam logic [3:0] STEP_P_SQ    = 4'd3;
    localparam logic [3:0] STEP_P_X2    = 4'd4;
    localparam logic [3:0] STEP_P_B3    = 4'd5;
    localparam logic [3:0] STEP_P_X1    = 4'd6;
    localparam logic [3:0] STEP_P_X3    = 4'd7;
    localparam logic [3:0] STEP_P_B4M   = 4'd8;
    localparam logic [3:0] STEP_P_B7M   = 4'd9;
    localparam logic [3:0] STEP_P_DIV   = 4'd10;
    localparam logic [3:0] STEP_P_PP    = 4'd11;
    localparam logic [3:0] STEP_P_CUBE  = 4'd12;
    localparam logic [3:0] STEP_P_X2P   = 4'd13;
    localparam logic [3:0] STEP_P_FIN   = 4'd14;

    state_t state_reg, state_next;

    logic [47:0] ac123_reg, ac456_reg;
    logic [31:0] b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    logic        cmd_reg;
    logic [23:0] raw_reg;
    logic [3:0]  step_reg;
    logic signed [31:0] b5_reg, b6_reg, sq_reg, x1_reg, x2_reg, b3_reg, x3v_reg;
    logic [31:0] b4_reg, p_reg;
    logic        neg_reg, b7hi_reg;

    logic [15:0] res_temp_reg;
    logic [17:0] res_pres_reg;
    logic        res_err_reg;

    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic        m_user_reg;

    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] mul_a, mul_b, prod;
    logic signed [31:0] prod_s;
    logic        div_start;
    logic [31:0] div_dividend, div_divisor, quotient;
    div_status_t div_status;

    logic signed [31:0] t_x1, t_den, mc_shift, t_x2, t_b5, t_t;
    logic signed [31:0] p_t0, p_t1, p_b3, p_x3, p_up, p_x1f, p_sum, p_fin;
    logic [31:0] mc_abs, den_abs, b7_k, p_pu;
    logic        load_out;

    assign ac1 = {{16{ac123_reg[47]}}, ac123_reg[47:32]};
    assign ac2 = {{16{ac123_reg[31]}}, ac123_reg[31:16]};
    assign ac3 = {{16{ac123_reg[15]}}, ac123_reg[15:0]};
    assign ac4 = {16'd0, ac456_reg[47:32]};
    assign ac5 = {16'd0, ac456_reg[31:16]};
    assign ac6 = {16'd0, ac456_reg[15:0]};
    assign b1  = {{16{b12_reg[31]}}, b12_reg[31:16]};
    assign b2  = {{16{b12_reg[15]}}, b12_reg[15:0]};
    assign mc  = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
    assign md  = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};

    assign prod_s = $signed(prod);

    bsc_multiplier u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    bsc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (quotient)
    );

    // temperature datapath
    assign t_x1     = prod_s >>> 15;
    assign t_den    = t_x1 + md;
    assign mc_shift = mc <<< 11;
    assign mc_abs   = mc_shift[31] ? 32'(-mc_shift) : 32'(mc_shift);
    assign den_abs  = t_den[31] ? 32'(-t_den) : 32'(t_den);
    assign t_x2     = neg_reg ? -$signed(quotient) : $signed(quotient);
    assign t_b5     = x1_reg + t_x2;
    assign t_t      = (t_b5 + 32'sd8) >>> 4;

    // pressure datapath
    assign p_t0  = (ac1 <<< 2) + x2_reg + (prod_s >>> 11);
    assign p_t1  = p_t0 <<< oss_reg;
    assign p_b3  = (p_t1 + 32'sd2) >>> 2;
    assign p_x3  = ((x1_reg + (prod_s >>> 16) + 32'sd2) >>> 2) + B4_OFFSET;
    assign p_up  = $signed({8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg}));
    assign b7_k  = B7_SCALE >> oss_reg;
    assign p_pu  = b7hi_reg ? {quotient[30:0], 1'b0} : quotient;
    assign p_x1f = $signed(p_reg) >>> 8;
    assign p_sum = (x1_reg + (prod_s >>> 16) + P_C3) >>> 4;
    assign p_fin = $signed(p_reg) + p_sum;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_T_MUL: begin
                mul_a = 32'($signed({16'd0, raw_reg[15:0]}) - ac6);
                mul_b = 32'(ac5);
            end
            STEP_P_SQM: begin
                mul_a = 32'(b6_reg);
                mul_b = 32'(b6_reg);
            end
            STEP_P_SQ: begin
                mul_a = 32'(ac2);
                mul_b = 32'(b6_reg);
            end
            STEP_P_X2: begin
                mul_a = 32'(b2);
                mul_b = 32'(sq_reg);
            end
            STEP_P_B3: begin
                mul_a = 32'(ac3);
                mul_b = 32'(b6_reg);
            end
            STEP_P_X1: begin
                mul_a = 32'(b1);
                mul_b = 32'(sq_reg);
            end
            STEP_P_B4M: begin
                mul_a = 32'(ac4);
                mul_b = 32'(x3v_reg);
            end
            STEP_P_B7M: begin
                mul_a = 32'(p_up - b3_reg);
                mul_b = b7_k;
            end
            STEP_P_PP: begin
                mul_a = 32'(p_x1f);
                mul_b = 32'(p_x1f);
            end
            STEP_P_CUBE: begin
                mul_a = prod;
                mul_b = 32'(P_C1);
            end
            STEP_P_X2P: begin
                mul_a = 32'(P_C2);
                mul_b = p_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = mc_abs;
        div_divisor  = den_abs;
        if (state_reg == ST_CALC && step_reg == STEP_T_DEN && t_den != 32'sd0) begin
            div_start = 1'b1;
        end
        if (state_reg == ST_CALC && step_reg == STEP_P_DIV && b4_reg != 32'd0) begin
            div_start    = 1'b1;
            div_dividend = (prod & SIGN_BIT) != 32'd0 ? prod : {prod[30:0], 1'b0};
            div_divisor  = b4_reg;
        end
    end

    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (step_reg == STEP_T_DEN) begin
                    state_next = (t_den == 32'sd0) ? ST_DONE : ST_DIV;
                end else if (step_reg == STEP_P_DIV) begin
                    state_next = (b4_reg == 32'd0) ? ST_DONE : ST_DIV;
                end else if (step_reg == STEP_P_FIN) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = cmd_reg ? ST_CALC : ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            b5_reg      <= '0;
            ac123_reg   <= '0;
            ac456_reg   <= '0;
            b12_reg     <= '0;
            mcmd_reg    <= '0;
            oss_reg     <= 2'd3;
            step_reg    <= STEP_T_MUL;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_AC123: ac123_reg <= cfg_data;
                    CFG_AC456: ac456_reg <= cfg_data;
                    CFG_B12:   b12_reg   <= cfg_data[31:0];
                    CFG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                    CFG_OSS:   oss_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= s_tuser[0] ? STEP_P_SQM : STEP_T_MUL;
                end
                ST_CALC: begin
                    step_reg <= step_reg + 4'd1;
                end
                ST_DIV: begin
                    if (div_status.done && !cmd_reg) begin
                        b5_reg <= t_b5;
                    end
                    step_reg <= STEP_P_PP;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            cmd_reg      <= s_tuser[0];
            raw_reg      <= s_tdata;
            b6_reg       <= b5_reg - B6_OFFSET;
            res_temp_reg <= '0;
            res_pres_reg <= '0;
            res_err_reg  <= 1'b0;
        end
        if (state_reg == ST_CALC) begin
            case (step_reg)
                STEP_T_DEN: begin
                    x1_reg  <= t_x1;
                    neg_reg <= mc_shift[31] ^ t_den[31];
                    if (t_den == 32'sd0) begin
                        res_err_reg <= 1'b1;
                    end
                end
                STEP_P_SQ:  sq_reg  <= prod_s >>> 12;
                STEP_P_X2:  x2_reg  <= prod_s >>> 11;
                STEP_P_B3:  b3_reg  <= p_b3;
                STEP_P_X1:  x1_reg  <= prod_s >>> 13;
                STEP_P_X3:  x3v_reg <= p_x3;
                STEP_P_B7M: b4_reg  <= prod >> 15;
                STEP_P_DIV: begin
                    b7hi_reg <= prod[31];
                    if (b4_reg == 32'd0) begin
                        res_err_reg <= 1'b1;
                    end
                end
                STEP_P_X2P: x1_reg <= prod_s >>> 16;
                STEP_P_FIN: begin
                    if (p_fin < 32'sd0) begin
                        res_pres_reg <= '0;
                    end else if (p_fin > 32'sd262143) begin
                        res_pres_reg <= '1;
                    end else begin
                        res_pres_reg <= p_fin[17:0];
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_DIV && div_status.done) begin
            if (cmd_reg) begin
                p_reg <= p_pu;
            end else if (t_t > 32'sd32767) begin
                res_temp_reg <= 16'h7fff;
            end else if (t_t < -32'sd32768) begin
                res_temp_reg <= 16'h8000;
            end else begin
                res_temp_reg <= t_t[15:0];
            end
        end
        if (load_out) begin
            m_data_reg <= {5'd0, res_err_reg, res_pres_reg, res_temp_reg};
            m_user_reg <= cmd_reg;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[33:0] == 34'd0)
        else $error("divide error with nonzero value fields");
    a_temp_no_pres: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[33:16] == 18'd0)
        else $error("temperature result with pressure value");
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_status.busy)
        else $error("ready while divider busy");
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after input transfer");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/bsc_multiplier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_multiplier
// Shared 32 by 32 multiplier, low word of the product, registered output.
// ----------------------------------------------------------------------------
module bsc_multiplier
    import bsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic [DataWidth-1:0] op_a,
    input  wire logic [DataWidth-1:0] op_b,
    output logic      [DataWidth-1:0] product
);

    logic [DataWidth-1:0] prod_low;
    logic [DataWidth-1:0] prod_reg;

    assign prod_low = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_low;
    end

    assign product = prod_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/bsc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsc_divider
    import bsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DataWidth-1:0] dividend,
    input  wire logic [DataWidth-1:0] divisor,
    output div_status_t               status,
    output logic      [DataWidth-1:0] quotient
);

    localparam int unsigned CntWidth = $clog2(DataWidth + 1);

    logic [DataWidth-1:0] rem_reg;
    logic [DataWidth-1:0] quo_reg;
    logic [DataWidth-1:0] dvs_reg;
    logic [CntWidth-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DataWidth:0]   rem_shift;
    logic [DataWidth:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[DataWidth-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntWidth'(DataWidth);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntWidth'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DataWidth]) begin
                rem_reg <= diff[DataWidth-1:0];
                quo_reg <= {quo_reg[DataWidth-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[DataWidth-1:0];
                quo_reg <= {quo_reg[DataWidth-2:0], 1'b0};
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
`default_nettype wire
